FILE: src/rbtg_pkg.sv
// Package for the randomized block test sequencer.
// Holds widths, command and result codes, register indexes and the result type.
package rbtg_pkg;
  localparam int MaxSectors = 1024;
  localparam int MaxRun = 16;
  localparam int MaxWords = 1024;
  localparam int IdxW = 10;
  localparam int WposW = 10;

  localparam logic [2:0] CMD_NEXT = 3'd0;
  localparam logic [2:0] CMD_FETCH = 3'd1;
  localparam logic [2:0] CMD_READ = 3'd2;
  localparam logic [2:0] CMD_COUNT = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_WORD = 3'd1;
  localparam logic [2:0] KIND_VERDICT = 3'd2;
  localparam logic [2:0] KIND_XFER_ERR = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  localparam logic [2:0] REG_BASE = 3'd0;
  localparam logic [2:0] REG_REGION = 3'd1;
  localparam logic [2:0] REG_MAXRUN = 3'd2;
  localparam logic [2:0] REG_SEED = 3'd3;
  localparam logic [2:0] REG_BUDGET = 3'd4;
  localparam logic [2:0] REG_WORDS = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic        is_write;
    logic [31:0] address;
    logic [4:0]  run_length;
    logic [31:0] word;
    logic        mismatch;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] data;
  } item_t;

  // Controller to datapath.
  typedef struct packed {
    logic restart;   // start clear sweep, load seed and budget
    logic hdr_mod_i; // start sector modulo
    logic hdr_draw;  // one draw step (32 lfsr shifts)
    logic hdr_mod_o; // run length modulo
    logic hdr_fin;   // finish header, emit
    logic do_item;   // process item in hand (cmd 1/2/3 or abort/done)
  } ctl_t;

  typedef struct packed {
    logic busy;      // clear sweep running
    logic div_done;
  } sts_t;

  function automatic logic [31:0] step1(logic [31:0] q);
    return {q[30:0], q[31] ^ q[4] ^ q[0]};
  endfunction

  function automatic logic [31:0] draw(logic [31:0] q);
    logic [31:0] r;
    r = q;
    for (int k = 0; k < 32; k++) r = step1(r);
    return r;
  endfunction
endpackage

FILE: src/rbtg_if.sv
// Valid/ready channel interface for the block test sequencer.
// Depends on nothing; payload type is a parameter.
interface rbtg_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: src/rbtg_ctrl.sv
// Controller of the block test sequencer: sequences header computation and items.
// Depends on rbtg_pkg.
module rbtg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          in_cmd,
  input  logic                hdr_needed,
  input  logic                out_free,
  input  rbtg_pkg::sts_t      sts,
  output logic                in_ready,
  output rbtg_pkg::ctl_t      ctl
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MODI = 3'd1;
  localparam logic [2:0] S_DRAW = 3'd2;
  localparam logic [2:0] S_MODO = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;

  logic [2:0] state, state_next;
  logic take;

  assign in_ready = (state == S_IDLE) && !sts.busy && out_free;
  assign take = in_valid && in_ready;

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (in_cmd == rbtg_pkg::CMD_RESTART) begin
            ctl.restart = 1'b1;
          end else if (in_cmd == rbtg_pkg::CMD_NEXT && hdr_needed) begin
            ctl.hdr_mod_i = 1'b1;
            state_next = S_MODI;
          end else begin
            ctl.do_item = 1'b1;
          end
        end
      end
      S_MODI: if (sts.div_done) begin
        ctl.hdr_draw = 1'b1;
        state_next = S_DRAW;
      end
      S_DRAW: begin
        ctl.hdr_mod_o = 1'b1;
        state_next = S_MODO;
      end
      S_MODO: if (sts.div_done) begin
        state_next = S_FIN;
      end
      S_FIN: begin
        ctl.hdr_fin = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

FILE: src/rbtg_datapath.sv
// Datapath of the block test sequencer: lfsr, pattern table, counters, divider.
// Depends on rbtg_pkg; driven by rbtg_ctrl commands.
module rbtg_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  rbtg_pkg::ctl_t       ctl,
  input  rbtg_pkg::item_t      item,
  input  logic [31:0]          base_sector,
  input  logic [10:0]          region_sectors,
  input  logic [4:0]           max_run,
  input  logic [31:0]          seed_value,
  input  logic [31:0]          op_budget,
  input  logic [10:0]          sector_words,
  input  logic                 out_ready,
  output logic                 out_valid,
  output rbtg_pkg::result_t    out_res,
  output logic                 out_free,
  output logic                 hdr_needed,
  output rbtg_pkg::sts_t       sts
);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WFILL = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;
  localparam logic [1:0] PH_RCHECK = 2'd3;

  logic [31:0] lfsr, ops_left, running_pattern;
  logic [9:0]  run_start;
  logic [4:0]  run_count, sector_pos;
  logic        run_is_write, sector_bad, aborted;
  logic [9:0]  word_pos;
  logic [1:0]  phase;

  // pattern memory, cleared by a sweep after reset or restart
  logic [31:0] mem [rbtg_pkg::MaxSectors];
  logic        clr_busy;
  logic [9:0]  clr_addr;
  logic [31:0] rd_data;
  logic [9:0]  idx;
  logic        mem_we;
  logic [9:0]  mem_wa;
  logic [31:0] mem_wd;

  // item staged in a register while the table read settles
  logic        stg_valid;
  rbtg_pkg::item_t stg;

  // serial divider: 32 / 11 bit remainder
  logic        div_busy, div_done;
  logic [5:0]  div_cnt;
  logic [31:0] div_q;
  logic [10:0] div_r, div_d;
  logic [11:0] div_trial;

  logic [10:0] region, words;
  logic [4:0]  mr;
  logic [9:0]  hdr_i;
  logic [4:0]  hdr_o;

  // hdr_o is latched on the second divider completion only
  logic        hdr_fin_seen;

  assign region = (region_sectors == 11'd0) ? 11'd1 :
                  (region_sectors > 11'd1024) ? 11'd1024 : region_sectors;
  assign words = (sector_words == 11'd0) ? 11'd1 :
                 (sector_words > 11'd1024) ? 11'd1024 : sector_words;
  assign mr = (max_run == 5'd0) ? 5'd1 : (max_run > 5'd16) ? 5'd16 : max_run;
  assign idx = run_start + 10'(sector_pos);
  assign hdr_needed = (phase == PH_IDLE) && !aborted && (ops_left != 32'd0);
  assign sts.busy = clr_busy;
  assign sts.div_done = div_done;
  assign div_trial = {div_r, div_q[31]};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (ctl.hdr_mod_i || ctl.hdr_mod_o) begin
        div_busy <= 1'b1;
        div_cnt <= 6'd0;
        div_r <= '0;
        div_q <= lfsr;
        div_d <= ctl.hdr_mod_i ? region : 11'(mr - 5'd1);
      end else if (div_busy) begin
        div_q <= {div_q[30:0], 1'b0};
        div_r <= (div_trial >= {1'b0, div_d}) ? 11'(div_trial - {1'b0, div_d})
                                               : div_trial[10:0];
        div_cnt <= div_cnt + 6'd1;
        if (div_cnt == 6'd31) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  logic [10:0] o_full;
  assign o_full = (mr > 5'd1) ? (div_r + 11'd1) : 11'd1;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = lfsr;
    if (clr_busy) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else if (stg_valid && stg.cmd == rbtg_pkg::CMD_FETCH && phase == PH_WFILL
                 && word_pos == 10'd0) begin
      mem_we = 1'b1;
    end else if (stg_valid && stg.cmd == rbtg_pkg::CMD_READ && phase == PH_RCHECK
                 && 11'(word_pos) + 11'd1 >= words) begin
      mem_we = sector_bad ||
               (rd_data != 32'd0 && stg.data != ((word_pos == 10'd0) ? rd_data
                                                 : running_pattern));
      mem_wd = '0;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    logic [31:0] pat, lfsr_n;
    logic [31:0] addr;
    logic        bad;
    if (rst || ctl.restart) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      lfsr <= seed_value;
      ops_left <= op_budget;
      run_start <= '0;
      run_count <= '0;
      run_is_write <= 1'b0;
      sector_pos <= '0;
      word_pos <= '0;
      running_pattern <= '0;
      sector_bad <= 1'b0;
      aborted <= 1'b0;
      phase <= PH_IDLE;
      stg_valid <= 1'b0;
      if (rst) out_valid <= 1'b0;
      else if (out_ready) out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (clr_busy) begin
        clr_addr <= clr_addr + 10'd1;
        if (clr_addr == 10'(rbtg_pkg::MaxSectors - 1)) clr_busy <= 1'b0;
      end
      stg_valid <= ctl.do_item;
      if (ctl.do_item) stg <= item;
      if (ctl.hdr_draw) begin
        hdr_i <= div_r[9:0];
        lfsr <= rbtg_pkg::draw(lfsr);
      end
      if (div_done && !ctl.hdr_draw && !div_busy && phase == PH_IDLE && !hdr_fin_seen)
        hdr_o <= (11'(hdr_i) + o_full > region) ? 5'(region - 11'(hdr_i)) : 5'(o_full);
      if (ctl.hdr_fin) begin
        lfsr_n = rbtg_pkg::draw(lfsr);
        run_is_write <= lfsr_n[0];
        lfsr <= rbtg_pkg::step1(lfsr_n);
        ops_left <= ops_left - 32'd1;
        run_start <= hdr_i;
        run_count <= hdr_o;
        sector_pos <= '0;
        word_pos <= '0;
        sector_bad <= 1'b0;
        phase <= lfsr_n[0] ? PH_WFILL : PH_COUNT;
        out_valid <= 1'b1;
        out_res <= '{rbtg_pkg::KIND_HEADER, lfsr_n[0], base_sector + 32'(hdr_i),
                     hdr_o, 32'd0, 1'b0, 1'b0};
      end
      addr = base_sector + 32'(run_start) + 32'(sector_pos);
      if (stg_valid) begin
        case (stg.cmd)
          rbtg_pkg::CMD_NEXT: begin
            if (phase == PH_IDLE) begin
              out_valid <= 1'b1;
              if (aborted)
                out_res <= '{rbtg_pkg::KIND_XFER_ERR, run_is_write,
                             base_sector + 32'(run_start), run_count, 32'd0, 1'b0, 1'b0};
              else
                out_res <= '{rbtg_pkg::KIND_DONE, 1'b0, 32'd0, 5'd0, 32'd0, 1'b0, 1'b0};
            end
          end
          rbtg_pkg::CMD_FETCH: begin
            if (phase == PH_WFILL) begin
              pat = (word_pos == 10'd0) ? lfsr : running_pattern;
              running_pattern <= pat + 32'd1;
              out_valid <= 1'b1;
              if (11'(word_pos) + 11'd1 >= words) begin
                word_pos <= '0;
                lfsr <= rbtg_pkg::draw(lfsr);
                sector_pos <= sector_pos + 5'd1;
                if (sector_pos + 5'd1 >= run_count) phase <= PH_COUNT;
                out_res <= '{rbtg_pkg::KIND_WORD, 1'b1, addr, run_count, pat, 1'b0,
                             sector_pos + 5'd1 >= run_count};
              end else begin
                word_pos <= word_pos + 10'd1;
                out_res <= '{rbtg_pkg::KIND_WORD, 1'b1, addr, run_count, pat, 1'b0, 1'b0};
              end
            end
          end
          rbtg_pkg::CMD_COUNT: begin
            if (phase == PH_COUNT) begin
              if (stg.data != 32'(run_count)) begin
                aborted <= 1'b1;
                phase <= PH_IDLE;
                out_valid <= 1'b1;
                out_res <= '{rbtg_pkg::KIND_XFER_ERR, run_is_write,
                             base_sector + 32'(run_start), run_count, 32'd0, 1'b0, 1'b0};
              end else if (run_is_write) begin
                phase <= PH_IDLE;
              end else begin
                phase <= PH_RCHECK;
                sector_pos <= '0;
                word_pos <= '0;
                sector_bad <= 1'b0;
              end
            end
          end
          rbtg_pkg::CMD_READ: begin
            if (phase == PH_RCHECK) begin
              pat = (word_pos == 10'd0) ? rd_data : running_pattern;
              bad = ((word_pos == 10'd0) ? 1'b0 : sector_bad) ||
                    (rd_data != 32'd0 && stg.data != pat);
              running_pattern <= pat + 32'd1;
              if (11'(word_pos) + 11'd1 >= words) begin
                word_pos <= '0;
                sector_bad <= 1'b0;
                sector_pos <= sector_pos + 5'd1;
                if (sector_pos + 5'd1 >= run_count) phase <= PH_IDLE;
                out_valid <= 1'b1;
                out_res <= '{rbtg_pkg::KIND_VERDICT, 1'b0, addr, run_count, rd_data, bad,
                             sector_pos + 5'd1 >= run_count};
              end else begin
                word_pos <= word_pos + 10'd1;
                sector_bad <= bad;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.hdr_mod_i) hdr_fin_seen <= 1'b1;
    else if (ctl.hdr_draw) hdr_fin_seen <= 1'b0;
    else if (ctl.hdr_fin) hdr_fin_seen <= 1'b1;
  end
endmodule

FILE: src/random_block_test_generator_checker_core.sv
// Randomized block test sequencer, top level.
// Data items (write word, read word, count): the beat is staged, then any result is
// registered; the next beat is held while the staged item resolves, one item at a time.
// Operation header: result set by two 32-step serial remainders and a draw step;
// no beat is taken until it is emitted. Reset and restart clear the 1024-entry
// pattern table in a sweep, no item accepted. Reset is synchronous, active high.
module random_block_test_generator_checker_core (
  input  logic        clk,
  input  logic        rst,
  rbtg_if.sink        in_ch,
  rbtg_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] base_sector, seed_value, op_budget;
  logic [10:0] region_sectors, sector_words;
  logic [4:0]  max_run;
  rbtg_pkg::ctl_t ctl;
  rbtg_pkg::sts_t sts;
  logic out_free, hdr_needed, stg_hold;
  rbtg_pkg::item_t item;
  logic ctl_ready;

  assign item = in_ch.payload;
  // hold the next beat while a staged item is still resolving
  assign in_ch.ready = ctl_ready && !stg_hold;

  always_ff @(posedge clk) begin
    if (rst) stg_hold <= 1'b0;
    else stg_hold <= in_ch.valid && in_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_sector <= '0;
      region_sectors <= 11'd1;
      max_run <= 5'd1;
      seed_value <= 32'd1234;
      op_budget <= 32'd100;
      sector_words <= 11'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        rbtg_pkg::REG_BASE: base_sector <= cfg_data;
        rbtg_pkg::REG_REGION: region_sectors <= cfg_data[10:0];
        rbtg_pkg::REG_MAXRUN: max_run <= cfg_data[4:0];
        rbtg_pkg::REG_SEED: seed_value <= cfg_data;
        rbtg_pkg::REG_BUDGET: op_budget <= cfg_data;
        rbtg_pkg::REG_WORDS: sector_words <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  rbtg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid && !stg_hold), .in_cmd(item.cmd),
    .hdr_needed(hdr_needed), .out_free(out_free), .sts(sts),
    .in_ready(ctl_ready), .ctl(ctl)
  );

  rbtg_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .item(item),
    .base_sector(base_sector), .region_sectors(region_sectors), .max_run(max_run),
    .seed_value(seed_value), .op_budget(op_budget), .sector_words(sector_words),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_res(out_ch.payload),
    .out_free(out_free), .hdr_needed(hdr_needed), .sts(sts)
  );
endmodule

FILE: src/rbtg_checker.sv
// Port-level checks for the block test sequencer; bound to the top level.
// Depends on rbtg_pkg and rbtg_if.
module rbtg_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rbtg_pkg::result_t out_res
);
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("beat taken on consecutive cycles");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res)) else $error("result dropped");
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == rbtg_pkg::KIND_DONE |-> out_res.address == 32'd0)
    else $error("finished result carries address");
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind random_block_test_generator_checker_core rbtg_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_ch.payload)
);
